>>> rtl/cfst_pkg.sv
// ----------------------------------------------------------------------------
// cfst_pkg: shared types and constants for the com state feedback trajectory
// Widths, fixed-point constants, register indexes and the microprogram.
// ----------------------------------------------------------------------------
package cfst_pkg;

   localparam int DataW        = 32;
   localparam int FracBits     = 24;
   localparam int PatternTicks = 125;
   localparam int SegmentTicks = 25;
   localparam int SegCount     = (PatternTicks + SegmentTicks - 1) / SegmentTicks;
   localparam int TickW        = 7;
   localparam int SegPosW      = $clog2(SegmentTicks + 1);
   localparam int SegNumW      = $clog2(SegCount + 1);
   localparam int CrouchW      = 8;
   localparam int MagW         = 31;
   localparam int CmpW         = (TickW + 1 > CrouchW) ? TickW + 1 : CrouchW;
   localparam int IdxW         = 3;
   localparam int ProdW        = 2 * DataW - FracBits;
   localparam int AccW         = ProdW + 2;
   localparam int ProgLen      = 9;
   localparam int StepW        = $clog2(ProgLen);

   localparam logic signed [DataW-1:0] Coef005 =
      DataW'(((longint'(1) << FracBits) * 5 + 50) / 100);
   localparam logic signed [DataW-1:0] Coef0013 =
      DataW'(((longint'(1) << FracBits) * 13 + 5000) / 10000);

   localparam logic signed [DataW-1:0] GainPosReset   = 32'sd15956810;
   localparam logic signed [DataW-1:0] GainVelReset   = 32'sd32492434;
   localparam logic signed [DataW-1:0] GainAccReset   = 32'sd32819590;
   localparam logic [MagW-1:0]         AmplitudeReset = 31'd637534;
   localparam logic [MagW-1:0]         CrouchStepReset = 31'd16777;
   localparam logic [CrouchW-1:0]      CrouchTicksReset = 8'd30;
   localparam logic [MagW-1:0]         StartHeightReset = 31'd3187671;

   typedef enum logic [IdxW-1:0] {
      REG_GAIN_POSITION = 3'd0,
      REG_GAIN_VELOCITY = 3'd1,
      REG_GAIN_ACCEL    = 3'd2,
      REG_REF_AMPLITUDE = 3'd3,
      REG_CROUCH_STEP   = 3'd4,
      REG_CROUCH_TICKS  = 3'd5,
      REG_START_HEIGHT  = 3'd6
   } csr_idx_type;

   typedef enum logic [1:0] {OPA_X0, OPA_X1, OPA_X2, OPA_U} opa_type;
   typedef enum logic [2:0] {OPB_K0, OPB_K1, OPB_K2, OPB_C005, OPB_C0013} opb_type;
   typedef enum logic [2:0] {ACC_ZERO, ACC_SELF, ACC_X0, ACC_X1, ACC_X2} acc_base_type;
   typedef enum logic [2:0] {WB_NONE, WB_FB, WB_X0, WB_X1, WB_X2} wb_type;

   typedef struct packed {
      logic         mul_en;
      opa_type      opa;
      opb_type      opb;
      logic         acc_en;
      acc_base_type acc_base;
      wb_type       wb;
      logic         calc_u;
      logic         last;
   } uword_type;

   localparam uword_type UwordIdle = '0;

   // steps 0 to 7 each issue one product; steps 1 to 8 fold in the product of the step before
   function automatic uword_type ucode(input logic [StepW-1:0] step);
      uword_type w;
      w = '0;
      unique case (step)
         StepW'(0): begin
            w.mul_en = 1'b1; w.opa = OPA_X0; w.opb = OPB_K0;
         end
         StepW'(1): begin
            w.mul_en = 1'b1; w.opa = OPA_X1; w.opb = OPB_K1;
            w.acc_en = 1'b1; w.acc_base = ACC_ZERO;
         end
         StepW'(2): begin
            w.mul_en = 1'b1; w.opa = OPA_X2; w.opb = OPB_K2;
            w.acc_en = 1'b1; w.acc_base = ACC_SELF;
         end
         StepW'(3): begin
            w.mul_en = 1'b1; w.opa = OPA_X1; w.opb = OPB_C005;
            w.acc_en = 1'b1; w.acc_base = ACC_SELF; w.wb = WB_FB;
         end
         StepW'(4): begin
            w.mul_en = 1'b1; w.opa = OPA_X2; w.opb = OPB_C0013;
            w.acc_en = 1'b1; w.acc_base = ACC_X0; w.calc_u = 1'b1;
         end
         StepW'(5): begin
            w.mul_en = 1'b1; w.opa = OPA_X2; w.opb = OPB_C005;
            w.acc_en = 1'b1; w.acc_base = ACC_SELF; w.wb = WB_X0;
         end
         StepW'(6): begin
            w.mul_en = 1'b1; w.opa = OPA_U; w.opb = OPB_C0013;
            w.acc_en = 1'b1; w.acc_base = ACC_X1;
         end
         StepW'(7): begin
            w.mul_en = 1'b1; w.opa = OPA_U; w.opb = OPB_C005;
            w.acc_en = 1'b1; w.acc_base = ACC_SELF; w.wb = WB_X1;
         end
         StepW'(8): begin
            w.acc_en = 1'b1; w.acc_base = ACC_X2; w.wb = WB_X2; w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   // clamp a wide signed value to the data word
   function automatic logic signed [DataW-1:0] sat_word(input logic signed [AccW-1:0] v);
      logic in_range;
      in_range = (&v[AccW-1:DataW-1]) || !(|v[AccW-1:DataW-1]);
      if (in_range) begin
         return v[DataW-1:0];
      end
      return {v[AccW-1], {(DataW-1){~v[AccW-1]}}};
   endfunction

endpackage

>>> rtl/cfst_req_if.sv
// ----------------------------------------------------------------------------
// cfst_req_if: tick channel
// Valid/ready handshake carrying one control tick per word.
// ----------------------------------------------------------------------------
interface cfst_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

>>> rtl/cfst_rsp_if.sv
// ----------------------------------------------------------------------------
// cfst_rsp_if: trajectory result channel
// Valid/ready handshake carrying position, height, phase and pattern index.
// ----------------------------------------------------------------------------
interface cfst_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] com_forward;
   logic signed [31:0] com_height;
   logic               walking;
   logic [6:0]         pattern_index;

   modport source (output valid, output com_forward, output com_height,
                   output walking, output pattern_index, input ready);
   modport sink   (input valid, input com_forward, input com_height,
                   input walking, input pattern_index, output ready);
endinterface

>>> rtl/com_state_feedback_trajectory.sv
// ----------------------------------------------------------------------------
// com_state_feedback_trajectory: centre-of-mass trajectory generator
// Crouch phase followed by a state-feedback tracking loop on a three-state
// plant, in signed Q8.24 with saturation.
// ----------------------------------------------------------------------------
// One tick word is taken at a time. A zero tick or a crouch tick gives its
// result in the cycle after acceptance. A walk tick runs a 9-step
// microprogram on one shared rounding multiplier and accumulator (fb = K.x,
// u = ref - fb, then the three new states) before its result is offered.
// Registers are to be written through the csr port only while no word is in
// flight; the block itself does not enforce this. Writing the start height
// also reloads the held height.
module com_state_feedback_trajectory (
   input  logic                          clock,
   input  logic                          reset,
   cfst_req_if.sink                      req_ch,
   cfst_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [cfst_pkg::IdxW-1:0]     csr_index,
   input  logic [cfst_pkg::DataW-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type                              state_ff, state_in;
   logic [cfst_pkg::StepW-1:0]             step_ff, step_in;
   logic signed [cfst_pkg::DataW-1:0]      height_ff, height_in;
   logic [cfst_pkg::TickW-1:0]             tick_ff, tick_in;
   logic [cfst_pkg::SegPosW-1:0]           seg_pos_ff, seg_pos_in;
   logic [cfst_pkg::SegNumW-1:0]           seg_num_ff, seg_num_in;
   logic                                   walk_ff, walk_in;

   logic signed [cfst_pkg::DataW-1:0]      gain_k0_ff, gain_k1_ff, gain_k2_ff;
   logic [cfst_pkg::MagW-1:0]              amp_ff, crouch_step_ff;
   logic [cfst_pkg::CrouchW-1:0]           crouch_ticks_ff;

   cfst_pkg::uword_type                    uword;
   logic signed [cfst_pkg::DataW-1:0]      ref_value, amp_word, x0;
   logic signed [cfst_pkg::DataW:0]        height_diff;
   logic                                   req_fire, advance;

   // counter values after one tick
   logic [cfst_pkg::CmpW-1:0]              tick_inc;
   logic [cfst_pkg::TickW-1:0]             adv_tick;
   logic [cfst_pkg::SegPosW-1:0]           adv_seg_pos;
   logic [cfst_pkg::SegNumW-1:0]           adv_seg_num;
   logic                                   adv_walk;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign uword    = (state_ff == ST_RUN) ? cfst_pkg::ucode(step_ff) : cfst_pkg::UwordIdle;

   assign amp_word  = signed'({1'b0, amp_ff});
   assign ref_value = (seg_num_ff == '0) ? '0 : (seg_num_ff[0] ? amp_word : -amp_word);

   assign height_diff = (cfst_pkg::DataW+1)'(height_ff)
                        - (cfst_pkg::DataW+1)'(signed'({1'b0, crouch_step_ff}));

   always_comb begin
      tick_inc    = cfst_pkg::CmpW'(tick_ff) + cfst_pkg::CmpW'(1);
      adv_tick    = tick_inc[cfst_pkg::TickW-1:0];
      adv_walk    = walk_ff;
      if (seg_pos_ff == cfst_pkg::SegPosW'(cfst_pkg::SegmentTicks - 1)) begin
         adv_seg_pos = '0;
         adv_seg_num = seg_num_ff + cfst_pkg::SegNumW'(1);
      end else begin
         adv_seg_pos = seg_pos_ff + cfst_pkg::SegPosW'(1);
         adv_seg_num = seg_num_ff;
      end
      // crouch ends on a match; the pattern wrap applies in both phases
      if (!walk_ff && tick_inc == cfst_pkg::CmpW'(crouch_ticks_ff)) begin
         adv_walk    = 1'b1;
         adv_tick    = '0;
         adv_seg_pos = '0;
         adv_seg_num = '0;
      end
      if (tick_inc >= cfst_pkg::CmpW'(cfst_pkg::PatternTicks)) begin
         adv_tick    = '0;
         adv_seg_pos = '0;
         adv_seg_num = '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      height_in = height_ff;
      advance   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_ch.tick) begin
                  state_in = ST_OUT;
               end else if (!walk_ff) begin
                  height_in = cfst_pkg::sat_word(cfst_pkg::AccW'(height_diff));
                  advance   = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  step_in  = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + cfst_pkg::StepW'(1);
            if (uword.last) begin
               advance  = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_index == cfst_pkg::REG_START_HEIGHT) begin
         height_in = signed'({1'b0, csr_wdata[cfst_pkg::MagW-1:0]});
      end
   end

   assign tick_in    = advance ? adv_tick    : tick_ff;
   assign seg_pos_in = advance ? adv_seg_pos : seg_pos_ff;
   assign seg_num_in = advance ? adv_seg_num : seg_num_ff;
   assign walk_in    = advance ? adv_walk    : walk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         height_ff  <= signed'({1'b0, cfst_pkg::StartHeightReset});
         tick_ff    <= '0;
         seg_pos_ff <= '0;
         seg_num_ff <= '0;
         walk_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         height_ff  <= height_in;
         tick_ff    <= tick_in;
         seg_pos_ff <= seg_pos_in;
         seg_num_ff <= seg_num_in;
         walk_ff    <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_k0_ff      <= cfst_pkg::GainPosReset;
         gain_k1_ff      <= cfst_pkg::GainVelReset;
         gain_k2_ff      <= cfst_pkg::GainAccReset;
         amp_ff          <= cfst_pkg::AmplitudeReset;
         crouch_step_ff  <= cfst_pkg::CrouchStepReset;
         crouch_ticks_ff <= cfst_pkg::CrouchTicksReset;
      end else if (csr_we) begin
         unique case (csr_index)
            cfst_pkg::REG_GAIN_POSITION: gain_k0_ff <= csr_wdata;
            cfst_pkg::REG_GAIN_VELOCITY: gain_k1_ff <= csr_wdata;
            cfst_pkg::REG_GAIN_ACCEL:    gain_k2_ff <= csr_wdata;
            cfst_pkg::REG_REF_AMPLITUDE: amp_ff <= csr_wdata[cfst_pkg::MagW-1:0];
            cfst_pkg::REG_CROUCH_STEP:   crouch_step_ff <= csr_wdata[cfst_pkg::MagW-1:0];
            cfst_pkg::REG_CROUCH_TICKS:  crouch_ticks_ff <= csr_wdata[cfst_pkg::CrouchW-1:0];
            default: ;
         endcase
      end
   end

   cfst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .uword     (uword),
      .gain_k0   (gain_k0_ff),
      .gain_k1   (gain_k1_ff),
      .gain_k2   (gain_k2_ff),
      .ref_value (ref_value),
      .x0        (x0)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_OUT);
   assign rsp_ch.com_forward   = x0;
   assign rsp_ch.com_height    = height_ff;
   assign rsp_ch.walking       = walk_ff;
   assign rsp_ch.pattern_index = tick_ff;

endmodule

>>> rtl/cfst_datapath.sv
// ----------------------------------------------------------------------------
// cfst_datapath: shared multiply-accumulate datapath
// One rounding multiplier, an accumulator and the plant state, driven by
// the control word of the current microprogram step.
// ----------------------------------------------------------------------------
module cfst_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cfst_pkg::uword_type                 uword,
   input  logic signed [cfst_pkg::DataW-1:0]   gain_k0,
   input  logic signed [cfst_pkg::DataW-1:0]   gain_k1,
   input  logic signed [cfst_pkg::DataW-1:0]   gain_k2,
   input  logic signed [cfst_pkg::DataW-1:0]   ref_value,
   output logic signed [cfst_pkg::DataW-1:0]   x0
);

   localparam int PW = 2 * cfst_pkg::DataW;
   localparam logic signed [PW-1:0] RoundHalf = PW'(64'sd1 <<< (cfst_pkg::FracBits - 1));

   logic signed [cfst_pkg::DataW-1:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [cfst_pkg::DataW-1:0] fb_ff, fb_in, u_ff, u_in;
   logic signed [cfst_pkg::ProdW-1:0] p_ff, p_in;
   logic signed [cfst_pkg::AccW-1:0]  acc_ff, acc_in, acc_base;
   logic signed [cfst_pkg::DataW-1:0] opa, opb, acc_sat;
   logic signed [PW-1:0]              prod;
   logic signed [cfst_pkg::DataW:0]   u_diff;

   always_comb begin
      unique case (uword.opa)
         cfst_pkg::OPA_X0: opa = x0_ff;
         cfst_pkg::OPA_X1: opa = x1_ff;
         cfst_pkg::OPA_X2: opa = x2_ff;
         cfst_pkg::OPA_U:  opa = u_ff;
         default:          opa = x0_ff;
      endcase
      unique case (uword.opb)
         cfst_pkg::OPB_K0:    opb = gain_k0;
         cfst_pkg::OPB_K1:    opb = gain_k1;
         cfst_pkg::OPB_K2:    opb = gain_k2;
         cfst_pkg::OPB_C005:  opb = cfst_pkg::Coef005;
         cfst_pkg::OPB_C0013: opb = cfst_pkg::Coef0013;
         default:             opb = gain_k0;
      endcase
   end

   // rounded product, ties toward plus infinity
   assign prod = PW'(opa) * PW'(opb) + RoundHalf;
   assign p_in = uword.mul_en ? prod[PW-1:cfst_pkg::FracBits] : p_ff;

   always_comb begin
      unique case (uword.acc_base)
         cfst_pkg::ACC_ZERO: acc_base = '0;
         cfst_pkg::ACC_SELF: acc_base = acc_ff;
         cfst_pkg::ACC_X0:   acc_base = cfst_pkg::AccW'(x0_ff);
         cfst_pkg::ACC_X1:   acc_base = cfst_pkg::AccW'(x1_ff);
         cfst_pkg::ACC_X2:   acc_base = cfst_pkg::AccW'(x2_ff);
         default:            acc_base = '0;
      endcase
   end

   assign acc_in  = uword.acc_en ? acc_base + cfst_pkg::AccW'(p_ff) : acc_ff;
   assign acc_sat = cfst_pkg::sat_word(acc_in);

   assign u_diff = (cfst_pkg::DataW+1)'(ref_value) - (cfst_pkg::DataW+1)'(fb_ff);
   assign u_in   = uword.calc_u ? cfst_pkg::sat_word(cfst_pkg::AccW'(u_diff)) : u_ff;

   always_comb begin
      fb_in = fb_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      unique case (uword.wb)
         cfst_pkg::WB_NONE: ;
         cfst_pkg::WB_FB:   fb_in = acc_sat;
         cfst_pkg::WB_X0:   x0_in = acc_sat;
         cfst_pkg::WB_X1:   x1_in = acc_sat;
         cfst_pkg::WB_X2:   x2_in = acc_sat;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff <= '0;
         x1_ff <= '0;
         x2_ff <= '0;
      end else begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

   always_ff @(posedge clock) begin
      fb_ff  <= fb_in;
      u_ff   <= u_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
   end

   assign x0 = x0_ff;

endmodule

>>> rtl/cfst_checker.sv
// ----------------------------------------------------------------------------
// cfst_checker: port-level checks for the trajectory block
// Watches the tick and result channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cfst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_com_forward,
   input logic signed [31:0] rsp_com_height,
   input logic               rsp_walking,
   input logic [6:0]         rsp_pattern_index
);

   // result word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_com_forward) && $stable(rsp_com_height)
         && $stable(rsp_walking) && $stable(rsp_pattern_index))
      else $error("result word changed while stalled");

   // one word in flight: no new tick while a result is offered
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("tick accepted while a result is pending");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pattern_index < 7'(cfst_pkg::PatternTicks))
      else $error("pattern index past the pattern length");

   // the plant does not move while crouching
   a_crouch_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_walking |-> rsp_com_forward == 32'sd0)
      else $error("forward position moved during crouch");

endmodule

bind com_state_feedback_trajectory cfst_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_com_forward   (rsp_ch.com_forward),
   .rsp_com_height    (rsp_ch.com_height),
   .rsp_walking       (rsp_ch.walking),
   .rsp_pattern_index (rsp_ch.pattern_index)
);
